// File: src/itrd_pkg.sv
// shared types and constants for the integer to radix digits block
// no dependencies; imported by every other source file in the project
`timescale 1ns / 1ps

package itrd_pkg;

	localparam int DATA_W   = 32;
	localparam int RADIX_W  = 5;
	localparam int CHAR_W   = 7;
	localparam int CFG_W    = 64;
	localparam int CFG_IDX_W = 2;

	// register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_LENGTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LOW    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HIGH   = 2'd2;

	// character codes
	localparam logic [7:0] CHAR_PLUS  = 8'h2b;
	localparam logic [7:0] CHAR_MINUS = 8'h2d;
	localparam logic [7:0] CHAR_FIRST = 8'd32;

	// result of one division pass
	typedef struct packed {
		logic              done;
		logic [DATA_W-1:0] quot;
		logic [RADIX_W-1:0] rem;
	} div_res_t;

endpackage

// File: src/integer_to_radix_digits.sv
// top level: signed 32-bit integer to text in a configurable radix
// depends on itrd_pkg and instantiates the shared divider itrd_div
`timescale 1ns / 1ps

// usage
// - config port: cfg_we writes cfg_data into register cfg_index (0 alphabet
//   length, 1 characters 0..7, 2 characters 8..15); write only while idle
// - input channel: in_valid/in_ready/value; in_ready is high only while the
//   block has no value in work, one value is converted at a time
// - output channel: out_valid/out_ready/out_char/last_char; one transfer per
//   character, optional '-' first, then digits most significant first,
//   last_char set on the final character
// - an alphabet that fails the check gives no transfers; the value is dropped
// - each digit takes one pass of the bit-serial divider (one quotient bit a
//   cycle); all digits of a value are found before its first character,
//   then one character per cycle while the receiver keeps out_ready high
// - the output register parts both sides: a new value is taken while the
//   final character still waits for its transfer
// - a stalled receiver holds the character in the output register and the
//   emit sequencer waits
// - reset clears the configuration to zero, so nothing is emitted until a
//   valid alphabet is written

module integer_to_radix_digits
	import itrd_pkg::*;
#(
	parameter int MAX_ALPHABET = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// configuration write port
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_W-1:0]       cfg_data,
	// input channel
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic signed [DATA_W-1:0] value,
	// output channel
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [CHAR_W-1:0]      out_char,
	output logic                   last_char
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_DIV,
		S_EMIT
	} state_t;

	state_t state_q;

	// configuration registers
	logic [RADIX_W-1:0] alpha_len_q;
	logic [CFG_W-1:0]   alpha_low_q;
	logic [CFG_W-1:0]   alpha_high_q;
	logic [2*CFG_W-1:0] alpha_bytes;

	// conversion state
	logic               neg_q;
	logic               sign_pend_q;
	logic [5:0]         nd_q;        // digits stored, up to 32
	logic [DATA_W-1:0]  dividend_q;
	logic               div_start_q;
	logic [3:0]         digits_q [32];

	// output register
	logic               out_valid_q;
	logic [CHAR_W-1:0]  out_char_q;
	logic               last_q;

	logic               alpha_ok;
	logic [4:0]         rd_idx;
	logic [3:0]         rd_digit;
	logic [5:0]         nd_dec;
	logic               out_free;
	div_res_t           div_res;

	assign alpha_bytes = {alpha_high_q, alpha_low_q};

	// alphabet check: length, character range, sign characters and pairwise duplicates
	always_comb begin
		logic [7:0] ci;
		logic       bad;
		bad = 1'b0;
		for (int i = 0; i < 16; i++) begin
			ci = alpha_bytes[i*8 +: 8];
			if (5'(i) < alpha_len_q) begin
				if (ci < CHAR_FIRST || ci[7] || ci == CHAR_PLUS || ci == CHAR_MINUS)
					bad = 1'b1;
				for (int j = i + 1; j < 16; j++) begin
					if (5'(j) < alpha_len_q && alpha_bytes[j*8 +: 8] == ci)
						bad = 1'b1;
				end
			end
		end
		alpha_ok = !bad && alpha_len_q >= 5'd2 && alpha_len_q <= 5'(MAX_ALPHABET);
	end

	itrd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start_q),
		.dividend (dividend_q),
		.divisor  (alpha_len_q),
		.res      (div_res)
	);

	// digits come out least significant first, read back from the top
	assign nd_dec   = nd_q - 6'd1;
	assign rd_idx   = nd_dec[4:0];
	assign rd_digit = digits_q[rd_idx];
	assign out_free = !out_valid_q || out_ready;

	assign in_ready  = state_q == S_IDLE;
	assign out_valid = out_valid_q;
	assign out_char  = out_char_q;
	assign last_char = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			alpha_len_q  <= '0;
			alpha_low_q  <= '0;
			alpha_high_q <= '0;
			neg_q        <= 1'b0;
			sign_pend_q  <= 1'b0;
			nd_q         <= '0;
			dividend_q   <= '0;
			div_start_q  <= 1'b0;
			out_valid_q  <= 1'b0;
			out_char_q   <= '0;
			last_q       <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_LENGTH: alpha_len_q  <= cfg_data[RADIX_W-1:0];
					REG_LOW:    alpha_low_q  <= cfg_data;
					REG_HIGH:   alpha_high_q <= cfg_data;
					default: ;
				endcase
			end

			// transfer done frees the output register; while emitting, the
			// sequencer decides whether it is refilled
			if (out_valid_q && out_ready && state_q != S_EMIT)
				out_valid_q <= 1'b0;

			case (state_q)
				S_IDLE: begin
					div_start_q <= in_valid && alpha_ok;
					if (in_valid && alpha_ok) begin
						neg_q       <= value[DATA_W-1];
						dividend_q  <= value[DATA_W-1] ? (~value + 32'd1) : value;
						nd_q        <= '0;
						state_q     <= S_DIV;
					end
				end
				S_DIV: begin
					div_start_q <= div_res.done && div_res.quot != '0 && nd_q != 6'd31;
					if (div_res.done) begin
						nd_q <= nd_q + 6'd1;
						if (div_res.quot == '0 || nd_q == 6'd31) begin
							sign_pend_q <= neg_q;
							state_q     <= S_EMIT;
						end else begin
							dividend_q  <= div_res.quot;
						end
					end
				end
				S_EMIT: begin
					div_start_q <= 1'b0;
					if (out_free) begin
						out_valid_q <= 1'b1;
						if (sign_pend_q) begin
							out_char_q  <= CHAR_MINUS[CHAR_W-1:0];
							last_q      <= 1'b0;
							sign_pend_q <= 1'b0;
						end else begin
							out_char_q <= alpha_bytes[{rd_digit, 3'b000} +: CHAR_W];
							last_q     <= nd_q == 6'd1;
							nd_q       <= nd_dec;
							if (nd_q == 6'd1)
								state_q <= S_IDLE;
						end
					end
				end
				default: begin
					div_start_q <= 1'b0;
					state_q     <= S_IDLE;
				end
			endcase
		end
	end

	// digit store, written as each remainder comes out
	always_ff @(posedge clk) begin
		if (state_q == S_DIV && div_res.done)
			digits_q[nd_q[4:0]] <= div_res.rem[3:0];
	end

	// digit count stays within the store
	a_nd_range: assert property (@(posedge clk) disable iff (!arst_n)
		nd_q <= 6'd32)
		else $error("digit count beyond store depth");

	// divider finishes only while the sequencer waits for it
	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_res.done |-> state_q == S_DIV)
		else $error("divider done outside divide state");

	// emitting digits always has one left to send
	a_emit_digits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT && !sign_pend_q) |-> nd_q != 6'd0)
		else $error("emit state with no digit left");

	// a value with a bad alphabet is dropped without work
	a_bad_alpha_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && !alpha_ok) |=> (state_q == S_IDLE && !div_start_q))
		else $error("bad alphabet value started a conversion");

endmodule

// File: src/itrd_div.sv
// bit-serial restoring divider, 32-bit dividend by a 5-bit divisor
// depends on itrd_pkg for widths and the div_res_t result struct
`timescale 1ns / 1ps

module itrd_div
	import itrd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [DATA_W-1:0]  dividend,
	input  logic [RADIX_W-1:0] divisor,
	output div_res_t           res
);

	logic [DATA_W-1:0]  quot_q;
	logic [RADIX_W-1:0] rem_q;
	logic [RADIX_W-1:0] div_q;
	logic [4:0]         cnt_q;
	logic               busy_q;
	logic               done_q;

	logic [RADIX_W:0] trial;
	logic [RADIX_W:0] diff;
	logic             ge;

	assign trial = {rem_q, quot_q[DATA_W-1]};
	assign ge    = trial >= {1'b0, div_q};
	assign diff  = trial - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath, one quotient bit a cycle
	always_ff @(posedge clk) begin
		if (start) begin
			quot_q <= dividend;
			rem_q  <= '0;
			div_q  <= divisor;
		end else if (busy_q) begin
			quot_q <= {quot_q[DATA_W-2:0], ge};
			rem_q  <= ge ? diff[RADIX_W-1:0] : trial[RADIX_W-1:0];
		end
	end

	assign res.done = done_q;
	assign res.quot = quot_q;
	assign res.rem  = rem_q;

endmodule

// File: verif/itrd_text_checker.sv
`timescale 1ns / 1ps
// checker for integer_to_radix_digits: mirrors the alphabet registers, predicts
// the text of every accepted value and compares each character transfer
// depends on itrd_pkg

module itrd_text_checker
	import itrd_pkg::*;
#(
	parameter int MAX_ALPHABET = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [CFG_W-1:0]         cfg_data,
	input  logic                     in_valid,
	input  logic                     in_ready,
	input  logic signed [DATA_W-1:0] value,
	input  logic                     out_valid,
	input  logic                     out_ready,
	input  logic [CHAR_W-1:0]        out_char,
	input  logic                     last_char,
	output int unsigned              fail_count,
	output int unsigned              pending_chars
);

	localparam logic [7:0] CHAR_TOP = 8'd127;

	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		logic              last;
	} text_char_t;

	logic [RADIX_W-1:0] radix_mirror;
	logic [CFG_W-1:0]   chars_low_mirror;
	logic [CFG_W-1:0]   chars_high_mirror;
	text_char_t         expected_text[$];
	text_char_t         want;
	int unsigned        mismatches = 0;

	assign fail_count = mismatches;

	function automatic logic [7:0] digit_char(input logic [3:0] idx);
		logic [CFG_W-1:0] word;
		word = idx[3] ? chars_high_mirror : chars_low_mirror;
		return word[idx[2:0]*8 +: 8];
	endfunction

	function automatic bit alphabet_usable();
		int         n;
		logic [7:0] c;
		n = radix_mirror;
		if (n < 2 || n > MAX_ALPHABET || n > 16)
			return 1'b0;
		for (int i = 0; i < n; i++) begin
			c = digit_char(4'(i));
			if (c < CHAR_FIRST || c > CHAR_TOP || c == CHAR_PLUS || c == CHAR_MINUS)
				return 1'b0;
			for (int j = i + 1; j < n; j++)
				if (digit_char(4'(j)) == c)
					return 1'b0;
		end
		return 1'b1;
	endfunction

	// queue the characters of one value, sign first, digits msd first
	function automatic void predict_text(input logic [DATA_W-1:0] raw);
		logic [DATA_W:0] mag;
		logic [3:0]      digits[32];
		int              nd;
		logic [7:0]      c;
		text_char_t      item;
		if (!alphabet_usable())
			return;
		mag = raw[DATA_W-1] ? (33'h1_0000_0000 - {1'b0, raw}) : {1'b0, raw};
		nd = 0;
		do begin
			digits[nd] = 4'(mag % radix_mirror);
			mag = mag / radix_mirror;
			nd++;
		end while (mag != 0 && nd < 32);
		if (raw[DATA_W-1]) begin
			item.ch = CHAR_MINUS[CHAR_W-1:0];
			item.last = 1'b0;
			expected_text.push_back(item);
		end
		for (int k = nd - 1; k >= 0; k--) begin
			c = digit_char(digits[k]);
			item.ch = c[CHAR_W-1:0];
			item.last = (k == 0);
			expected_text.push_back(item);
		end
	endfunction

	task automatic report_mismatch(input string msg);
		$display("%0t ns: mismatch: %s", $time, msg);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_mirror = '0;
			chars_low_mirror = '0;
			chars_high_mirror = '0;
			expected_text.delete();
			pending_chars <= 0;
		end else begin
			// output first: a character leaving now belongs to an older value
			if (out_valid && out_ready) begin
				if (expected_text.size() == 0) begin
					report_mismatch($sformatf("unexpected character 0x%02h", out_char));
				end else begin
					want = expected_text.pop_front();
					if (out_char !== want.ch)
						report_mismatch($sformatf("out_char 0x%02h, expected 0x%02h",
							out_char, want.ch));
					if (last_char !== want.last)
						report_mismatch($sformatf("last_char %b, expected %b on 0x%02h",
							last_char, want.last, want.ch));
				end
			end
			if (in_valid && in_ready)
				predict_text(value);
			if (cfg_we) begin
				case (cfg_index)
					REG_LENGTH: radix_mirror = cfg_data[RADIX_W-1:0];
					REG_LOW:    chars_low_mirror = cfg_data;
					REG_HIGH:   chars_high_mirror = cfg_data;
					default:    ;
				endcase
			end
			pending_chars <= expected_text.size();
		end
	end

endmodule

// File: verif/integer_to_radix_digits_tb.sv
`timescale 1ns / 1ps
// testbench top for integer_to_radix_digits: clock, reset, alphabet setup,
// value stimulus, receiver flow control, watchdog and verdict
// depends on itrd_pkg, itrd_text_checker and the block under test

module integer_to_radix_digits_tb;
	import itrd_pkg::*;

	// settle pause covers a binary conversion of the most negative value
	localparam int SETTLE_CYCLES = 1200;
	// long receiver hold-off, so the block fills and drops in_ready
	localparam int HOLD_CYCLES   = 1500;
	// worst quiet stretch is hold-off plus one conversion plus one settle
	// pause; the limit is several times that
	localparam int QUIET_LIMIT   = 20000;
	localparam int RANDOM_ITEMS  = 250;
	localparam int PHASE_ITEMS   = 25;
	localparam int BAD_ITEMS     = 3;

	typedef enum int {
		FLOW_FREE,
		FLOW_SEND_IDLE,
		FLOW_RECV_STALL,
		FLOW_BOTH
	} flow_mode_t;

	// ways to spoil an otherwise good alphabet
	typedef enum int {
		BAD_SHORT,
		BAD_LONG,
		BAD_DUP,
		BAD_PLUS,
		BAD_MINUS,
		BAD_LOW,
		BAD_HIGH
	} alphabet_fault_t;

	logic                     clk;
	logic                     arst_n    = 1'b0;
	logic                     cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]     cfg_index = REG_LENGTH;
	logic [CFG_W-1:0]         cfg_data  = '0;
	logic                     in_valid  = 1'b0;
	logic                     in_ready;
	logic signed [DATA_W-1:0] value     = '0;
	logic                     out_valid;
	logic                     out_ready = 1'b0;
	logic [CHAR_W-1:0]        out_char;
	logic                     last_char;

	int unsigned fail_count;
	int unsigned pending_chars;
	int unsigned quiet_cycles;

	// flow control knobs, percent of cycles spent idle or stalled
	int unsigned send_idle_pct  = 0;
	int unsigned recv_stall_pct = 0;
	bit          hold_off_req   = 1'b0;

	integer_to_radix_digits uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.value     (value),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_char  (out_char),
		.last_char (last_char)
	);

	itrd_text_checker text_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.value         (value),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_char      (out_char),
		.last_char     (last_char),
		.fail_count    (fail_count),
		.pending_chars (pending_chars)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// watchdog: ends the run after too many cycles with no transfer or config write
	initial begin
		quiet_cycles = 0;
		while (quiet_cycles < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
		$display("*** FAILED ***");
		$finish;
	end

	function automatic logic [127:0] pack_text(input string s);
		logic [127:0] chars;
		chars = '0;
		for (int k = 0; k < s.len() && k < 16; k++)
			chars[k*8 +: 8] = s[k];
		return chars;
	endfunction

	task automatic set_flow(input flow_mode_t mode);
		case (mode)
			FLOW_FREE: begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end
			FLOW_SEND_IDLE: begin
				send_idle_pct = 60;
				recv_stall_pct = 0;
			end
			FLOW_RECV_STALL: begin
				send_idle_pct = 0;
				recv_stall_pct = 60;
			end
			default: begin
				send_idle_pct = 33;
				recv_stall_pct = 33;
			end
		endcase
	endtask

	// one input transfer; valid stays up after it so back-to-back values
	// need no gap, and is only lowered by a gap or by wait_idle
	task automatic send_value(input logic [DATA_W-1:0] v);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		value    <= v;
		do @(posedge clk); while (!in_ready);
	endtask

	// drain all expected text, then give a dropped value time to finish
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_chars != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// register writes only ever happen with the block idle
	task automatic load_alphabet(input logic [CFG_W-1:0] len_word, input logic [127:0] chars);
		wait_idle();
		cfg_we    <= 1'b1;
		cfg_index <= REG_LENGTH;
		cfg_data  <= len_word;
		@(posedge clk);
		cfg_index <= REG_LOW;
		cfg_data  <= chars[63:0];
		@(posedge clk);
		cfg_index <= REG_HIGH;
		cfg_data  <= chars[127:64];
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	initial begin
		logic [127:0]      chars;
		logic [CFG_W-1:0]  len_word;
		logic [DATA_W-1:0] v;
		alphabet_fault_t   fault;
		bit                used[128];
		bit                faulty;
		int unsigned       c;
		int                n;
		int                pos;
		int                src;
		int                sent;
		int                phase;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// ---------------- directed part ----------------

		// reset leaves an empty alphabet, so the value is dropped silently
		send_value(32'd12345);

		// decimal, the usual sign and extreme cases
		load_alphabet(64'd10, pack_text("0123456789"));
		set_flow(FLOW_FREE);
		send_value(32'd0);
		send_value(32'd1);
		send_value(32'hffff_ffff);
		send_value(32'h7fff_ffff);
		send_value(32'h8000_0000);
		send_value(-32'sd10);

		// binary, the smallest radix and the longest text; junk above the
		// five length bits must be ignored
		load_alphabet(64'hffff_ffff_ffff_ffe2, pack_text("01"));
		set_flow(FLOW_BOTH);
		send_value(32'h8000_0000);
		send_value(32'h7fff_ffff);
		send_value(32'd0);
		send_value(32'hffff_ffff);

		// full sixteen characters, space and DEL among them
		load_alphabet(64'd16, {64'h7f7e_2f2e_2c2a_2928, 64'h2726_2524_2322_2120});
		set_flow(FLOW_RECV_STALL);
		send_value(32'h8000_0000);
		send_value(32'h7fff_ffff);
		send_value(32'hffff_ffff);
		send_value(32'd0);
		send_value(32'hdead_beef);

		// radix 3; bytes past the length hold zero, plus, minus and high junk
		load_alphabet(64'd3, {64'hffff_ffff_ffff_ffff, 64'h0080_2d2b_0063_6261});
		set_flow(FLOW_SEND_IDLE);
		send_value(-32'sd7);

		// bad alphabets: each value must give no transfer at all
		set_flow(FLOW_FREE);
		load_alphabet(64'd1, pack_text("0"));
		send_value(32'd5);
		load_alphabet(64'd17, {64'h7f7e_2f2e_2c2a_2928, 64'h2726_2524_2322_2120});
		send_value(32'd5);
		load_alphabet(64'd31, {64'h7f7e_2f2e_2c2a_2928, 64'h2726_2524_2322_2120});
		send_value(-32'sd5);
		load_alphabet(64'd10, pack_text("0123456783"));
		send_value(32'd5);
		load_alphabet(64'd4, pack_text("01+3"));
		send_value(32'd5);
		load_alphabet(64'd2, pack_text("0-"));
		send_value(-32'sd1);
		// zero byte inside the used length
		load_alphabet(64'd3, 128'h32_00_30);
		send_value(32'd5);
		// byte with bit 7 set
		load_alphabet(64'd3, 128'h80_31_30);
		send_value(32'd5);
		// control character just below space
		load_alphabet(64'd2, 128'h31_1f);
		send_value(32'd5);

		// ---------------- random part ----------------

		sent = 0;
		phase = 0;
		while (sent < RANDOM_ITEMS) begin
			// mostly mid to large radix, radix 2 to 4 now and then
			n = ($urandom_range(3) == 0) ? $urandom_range(4, 2) : $urandom_range(16, 5);

			// distinct legal characters, random junk in the unused bytes
			foreach (used[k])
				used[k] = 1'b0;
			chars = {$urandom(), $urandom(), $urandom(), $urandom()};
			for (int k = 0; k < n; k++) begin
				do c = $urandom_range(127, 32);
				while (used[c] || c == CHAR_PLUS || c == CHAR_MINUS);
				used[c] = 1'b1;
				chars[k*8 +: 8] = c[7:0];
			end
			len_word = {$urandom(), $urandom()};
			len_word[RADIX_W-1:0] = RADIX_W'(n);

			// about one phase in five gets a spoiled alphabet; never the
			// first, which carries the long hold-off
			faulty = (phase != 0) && ($urandom_range(4) == 0);
			if (faulty) begin
				fault = alphabet_fault_t'($urandom_range(BAD_HIGH));
				pos = $urandom_range(n - 1);
				case (fault)
					BAD_SHORT: len_word[RADIX_W-1:0] = RADIX_W'($urandom_range(1));
					BAD_LONG:  len_word[RADIX_W-1:0] = RADIX_W'($urandom_range(31, 17));
					BAD_DUP: begin
						src = (pos + $urandom_range(n - 1, 1)) % n;
						chars[pos*8 +: 8] = chars[src*8 +: 8];
					end
					BAD_PLUS:  chars[pos*8 +: 8] = CHAR_PLUS;
					BAD_MINUS: chars[pos*8 +: 8] = CHAR_MINUS;
					BAD_LOW:   chars[pos*8 +: 8] = 8'($urandom_range(31));
					default:   chars[pos*8 +: 8] = 8'($urandom_range(255, 128));
				endcase
			end

			load_alphabet(len_word, chars);
			set_flow(flow_mode_t'(phase % 4));
			// first phase: receiver holds off while values keep coming
			if (phase == 0)
				hold_off_req = 1'b1;

			for (int i = 0; i < (faulty ? BAD_ITEMS : PHASE_ITEMS); i++) begin
				case ($urandom_range(9))
					0: begin
						case ($urandom_range(3))
							0:       v = 32'h8000_0000;
							1:       v = 32'h7fff_ffff;
							2:       v = '0;
							default: v = '1;
						endcase
					end
					1, 2, 3: begin
						// short text, a few digits of either sign
						v = $urandom_range(n * n * n);
						if ($urandom_range(1))
							v = -v;
					end
					default: v = $urandom();
				endcase
				send_value(v);
			end
			if (!faulty)
				sent += PHASE_ITEMS;
			phase++;
		end

		// drain, then a quiet tail in which no stray transfer may show up
		wait_idle();
		if (fail_count == 0 && pending_chars == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// File: filelist.f
src/itrd_pkg.sv
src/itrd_div.sv
src/integer_to_radix_digits.sv
verif/itrd_text_checker.sv
verif/integer_to_radix_digits_tb.sv
